### src/btcc_pkg.sv
// Shared types, register codes and result codes for the copy region checker.
package btcc_pkg;

    // Default widths of the descriptor fields.
    localparam int DEF_DIM_BITS       = 16;
    localparam int DEF_BYTE_ADDR_BITS = 40;

    // Quotient bits resolved per divider pipeline stage.
    localparam int DIV_STEPS = 6;

    // Configuration port geometry: eight 32-bit registers.
    localparam int CFG_ADDR_BITS = 5;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_BLOCK_WIDTH  = 3'd0;
    localparam logic [2:0] REG_BLOCK_HEIGHT = 3'd1;
    localparam logic [2:0] REG_BLOCK_BYTES  = 3'd2;
    localparam logic [2:0] REG_MIP_COUNT    = 3'd3;
    localparam logic [2:0] REG_TEX_WIDTH    = 3'd4;
    localparam logic [2:0] REG_TEX_HEIGHT   = 3'd5;
    localparam logic [2:0] REG_TEX_DEPTH    = 3'd6;
    localparam logic [2:0] REG_TEX_KIND     = 3'd7;

    // Texture dimension codes that change the layer math.
    localparam logic [1:0] KIND_3D   = 2'd2;
    localparam logic [1:0] KIND_CUBE = 2'd3;

    // Result status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_RANGE   = 2'd2;

    // Failed check codes, in priority order.
    localparam logic [2:0] CHK_NONE   = 3'd0;
    localparam logic [2:0] CHK_ALIGN  = 3'd1;
    localparam logic [2:0] CHK_MIP    = 3'd2;
    localparam logic [2:0] CHK_EXTENT = 3'd3;
    localparam logic [2:0] CHK_ROW    = 3'd4;
    localparam logic [2:0] CHK_RANGE  = 3'd5;
    localparam logic [2:0] CHK_END    = 3'd6;
    localparam logic [2:0] CHK_FACE   = 3'd7;

    // Texture description held in configuration.
    typedef struct packed {
        logic [4:0]  block_width;
        logic [4:0]  block_height;
        logic [5:0]  block_bytes;
        logic [4:0]  mip_count;
        logic [15:0] tex_width;
        logic [15:0] tex_height;
        logic [15:0] tex_depth;
        logic [1:0]  tex_kind;
    } btcc_cfg_t;

    localparam btcc_cfg_t CFG_RESET = '{
        block_width:  5'd1,
        block_height: 5'd1,
        block_bytes:  6'd4,
        mip_count:    5'd1,
        tex_width:    16'd1,
        tex_height:   16'd1,
        tex_depth:    16'd1,
        tex_kind:     2'd1
    };

    // Check outcomes settled before the divider.
    typedef struct packed {
        logic mip_bad;
        logic ext_bad;
        logic row_bad;
        logic ex_at_edge;
        logic ey_at_edge;
        logic face_bad;
        logic off_gt;
    } btcc_flags_t;

    localparam int FLAGS_W = $bits(btcc_flags_t);

endpackage

### src/buffer_texture_copy_region_check_core.sv
// Top level: configuration registers and the descriptor check pipeline.
// The restoring divider lanes resolve six quotient bits a stage. Throughput is
// one descriptor per cycle; busy stays low and every result is a single-cycle
// done strobe that the receiver cannot stall.
// Reset clears all pipeline valid bits and loads the register defaults.
module buffer_texture_copy_region_check_core import btcc_pkg::*; #(
    parameter int DIM_BITS       = DEF_DIM_BITS,
    parameter int BYTE_ADDR_BITS = DEF_BYTE_ADDR_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [CFG_ADDR_BITS-1:0]  paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      start,
    output logic                      busy,
    input  logic [DIM_BITS-1:0]       pos_x,
    input  logic [DIM_BITS-1:0]       pos_y,
    input  logic [4:0]                mip_level,
    input  logic [DIM_BITS-1:0]       layer_index,
    input  logic signed [3:0]         cube_face,
    input  logic [DIM_BITS-1:0]       copy_width,
    input  logic [DIM_BITS-1:0]       copy_height,
    input  logic [DIM_BITS-1:0]       layer_count,
    input  logic [DIM_BITS-1:0]       row_length,
    input  logic [DIM_BITS-1:0]       image_rows,
    input  logic [BYTE_ADDR_BITS-1:0] buffer_offset,
    input  logic [BYTE_ADDR_BITS-1:0] buffer_bytes,
    output logic                      done,
    output logic [1:0]                status,
    output logic [2:0]                failed_check
);

    localparam int EX_W   = (DIM_BITS < 32) ? DIM_BITS + 1 : 32;
    localparam int DW     = DIM_BITS + 1;
    localparam int LANES  = 7;
    localparam int SIDE_W = FLAGS_W + DIM_BITS + BYTE_ADDR_BITS;

    // Divider lane assignment.
    localparam int LANE_PX  = 0;
    localparam int LANE_PY  = 1;
    localparam int LANE_EX  = 2;
    localparam int LANE_EY  = 3;
    localparam int LANE_NBW = 4;
    localparam int LANE_NBH = 5;
    localparam int LANE_NCW = 6;

    btcc_cfg_t                   cfg_reg;
    logic                        cfg_wr;
    logic [2:0]                  cfg_idx;
    logic [4:0]                  bx, by;
    logic                        in_valid;

    logic                        fr_valid;
    btcc_flags_t                 fr_flags;
    logic [DW-1:0]               px_div, py_div, ex_div, ey_div;
    logic [DW-1:0]               nbw_div, nbh_div, ncw_div;
    logic [DIM_BITS-1:0]         fr_lc;
    logic [BYTE_ADDR_BITS-1:0]   fr_avail;

    logic [LANES-1:0][DW-1:0]    dividend;
    logic [LANES-1:0][4:0]       divisor;
    logic [SIDE_W-1:0]           side_in, side_out;
    logic                        dv_valid;
    logic [LANES-1:0][DW-1:0]    quotient;
    logic [LANES-1:0][4:0]       remainder;
    btcc_flags_t                 dv_flags;
    logic [DIM_BITS-1:0]         dv_lc;
    logic [BYTE_ADDR_BITS-1:0]   dv_avail;

    // Configuration write transfer and register file.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_BLOCK_WIDTH:  cfg_reg.block_width  <= pwdata[4:0];
                REG_BLOCK_HEIGHT: cfg_reg.block_height <= pwdata[4:0];
                REG_BLOCK_BYTES:  cfg_reg.block_bytes  <= pwdata[5:0];
                REG_MIP_COUNT:    cfg_reg.mip_count    <= pwdata[4:0];
                REG_TEX_WIDTH:    cfg_reg.tex_width    <= pwdata[15:0];
                REG_TEX_HEIGHT:   cfg_reg.tex_height   <= pwdata[15:0];
                REG_TEX_DEPTH:    cfg_reg.tex_depth    <= pwdata[15:0];
                REG_TEX_KIND:     cfg_reg.tex_kind     <= pwdata[1:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        case (cfg_idx)
            REG_BLOCK_WIDTH:  prdata = 32'(cfg_reg.block_width);
            REG_BLOCK_HEIGHT: prdata = 32'(cfg_reg.block_height);
            REG_BLOCK_BYTES:  prdata = 32'(cfg_reg.block_bytes);
            REG_MIP_COUNT:    prdata = 32'(cfg_reg.mip_count);
            REG_TEX_WIDTH:    prdata = 32'(cfg_reg.tex_width);
            REG_TEX_HEIGHT:   prdata = 32'(cfg_reg.tex_height);
            REG_TEX_DEPTH:    prdata = 32'(cfg_reg.tex_depth);
            REG_TEX_KIND:     prdata = 32'(cfg_reg.tex_kind);
            default:          prdata = 32'd0;
        endcase
    end

    // A zero block size counts as one.
    assign bx = (cfg_reg.block_width == 5'd0) ? 5'd1 : cfg_reg.block_width;
    assign by = (cfg_reg.block_height == 5'd0) ? 5'd1 : cfg_reg.block_height;

    // The pipeline never stalls, so every start is a transfer.
    assign busy     = 1'b0;
    assign in_valid = start && !busy;

    btcc_front #(
        .DIM_BITS       (DIM_BITS),
        .BYTE_ADDR_BITS (BYTE_ADDR_BITS),
        .EX_W           (EX_W),
        .DW             (DW)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .cfg           (cfg_reg),
        .bx            (bx),
        .by            (by),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .mip_level     (mip_level),
        .layer_index   (layer_index),
        .cube_face     (cube_face),
        .copy_width    (copy_width),
        .copy_height   (copy_height),
        .layer_count   (layer_count),
        .row_length    (row_length),
        .image_rows    (image_rows),
        .buffer_offset (buffer_offset),
        .buffer_bytes  (buffer_bytes),
        .out_valid     (fr_valid),
        .flags         (fr_flags),
        .px_div        (px_div),
        .py_div        (py_div),
        .ex_div        (ex_div),
        .ey_div        (ey_div),
        .nbw_div       (nbw_div),
        .nbh_div       (nbh_div),
        .ncw_div       (ncw_div),
        .lc_out        (fr_lc),
        .avail_out     (fr_avail)
    );

    // Divider lanes: remainders for alignment, quotients for block counts.
    always_comb
    begin
        dividend[LANE_PX]  = px_div;
        dividend[LANE_PY]  = py_div;
        dividend[LANE_EX]  = ex_div;
        dividend[LANE_EY]  = ey_div;
        dividend[LANE_NBW] = nbw_div;
        dividend[LANE_NBH] = nbh_div;
        dividend[LANE_NCW] = ncw_div;
        divisor[LANE_PX]   = bx;
        divisor[LANE_PY]   = by;
        divisor[LANE_EX]   = bx;
        divisor[LANE_EY]   = by;
        divisor[LANE_NBW]  = bx;
        divisor[LANE_NBH]  = by;
        divisor[LANE_NCW]  = bx;
    end

    assign side_in = {fr_flags, fr_lc, fr_avail};

    btcc_div #(
        .DW     (DW),
        .LANES  (LANES),
        .SIDE_W (SIDE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .dividend  (dividend),
        .divisor   (divisor),
        .side_in   (side_in),
        .out_valid (dv_valid),
        .quotient  (quotient),
        .remainder (remainder),
        .side_out  (side_out)
    );

    assign {dv_flags, dv_lc, dv_avail} = side_out;

    btcc_size #(
        .DIM_BITS       (DIM_BITS),
        .BYTE_ADDR_BITS (BYTE_ADDR_BITS),
        .DW             (DW)
    ) u_size (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (dv_valid),
        .flags        (dv_flags),
        .lc           (dv_lc),
        .avail        (dv_avail),
        .bxb          (quotient[LANE_NBW]),
        .byb          (quotient[LANE_NBH]),
        .txb          (quotient[LANE_NCW]),
        .rem_px       (remainder[LANE_PX]),
        .rem_py       (remainder[LANE_PY]),
        .rem_ex       (remainder[LANE_EX]),
        .rem_ey       (remainder[LANE_EY]),
        .block_bytes  (cfg_reg.block_bytes),
        .done         (done),
        .status       (status),
        .failed_check (failed_check)
    );

endmodule

### src/btcc_front.sv
// Front stages: mip extents, copy ends, layer range and divider operands.
module btcc_front import btcc_pkg::*; #(
    parameter int DIM_BITS       = DEF_DIM_BITS,
    parameter int BYTE_ADDR_BITS = DEF_BYTE_ADDR_BITS,
    parameter int EX_W           = DEF_DIM_BITS + 1,
    parameter int DW             = DEF_DIM_BITS + 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  btcc_cfg_t                 cfg,
    input  logic [4:0]                bx,
    input  logic [4:0]                by,
    input  logic [DIM_BITS-1:0]       pos_x,
    input  logic [DIM_BITS-1:0]       pos_y,
    input  logic [4:0]                mip_level,
    input  logic [DIM_BITS-1:0]       layer_index,
    input  logic signed [3:0]         cube_face,
    input  logic [DIM_BITS-1:0]       copy_width,
    input  logic [DIM_BITS-1:0]       copy_height,
    input  logic [DIM_BITS-1:0]       layer_count,
    input  logic [DIM_BITS-1:0]       row_length,
    input  logic [DIM_BITS-1:0]       image_rows,
    input  logic [BYTE_ADDR_BITS-1:0] buffer_offset,
    input  logic [BYTE_ADDR_BITS-1:0] buffer_bytes,
    output logic                      out_valid,
    output btcc_flags_t               flags,
    output logic [DW-1:0]             px_div,
    output logic [DW-1:0]             py_div,
    output logic [DW-1:0]             ex_div,
    output logic [DW-1:0]             ey_div,
    output logic [DW-1:0]             nbw_div,
    output logic [DW-1:0]             nbh_div,
    output logic [DW-1:0]             ncw_div,
    output logic [DIM_BITS-1:0]       lc_out,
    output logic [BYTE_ADDR_BITS-1:0] avail_out
);

    localparam int CMP_W = (EX_W > 16) ? EX_W : 16;

    function automatic logic [15:0] floor_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    // Stage one registers.
    logic                      v1_reg;
    logic                      mip_bad1_reg, mip_bad1_next;
    logic                      face_bad1_reg, face_bad1_next;
    logic                      off_gt1_reg, off_gt1_next;
    logic [BYTE_ADDR_BITS-1:0] avail1_reg, avail1_next;
    logic [15:0]               mw1_reg, mw1_next;
    logic [15:0]               mh1_reg, mh1_next;
    logic [18:0]               ml1_reg, ml1_next;
    logic [EX_W-1:0]           ex1_reg, ex1_next;
    logic [EX_W-1:0]           ey1_reg, ey1_next;
    logic [31:0]               loff1_reg, loff1_next;
    logic [DIM_BITS-1:0]       bw1_reg, bw1_next;
    logic [DIM_BITS-1:0]       bh1_reg, bh1_next;
    logic [DIM_BITS-1:0]       px1_reg, py1_reg, cw1_reg, ch1_reg, lc1_reg;

    // Stage two registers.
    logic                      v2_reg;
    btcc_flags_t               flags2_reg, flags2_next;
    logic [DW-1:0]             px2_reg, py2_reg, ex2_reg, ey2_reg;
    logic [DW-1:0]             nbw2_reg, nbw2_next;
    logic [DW-1:0]             nbh2_reg, nbh2_next;
    logic [DW-1:0]             ncw2_reg, ncw2_next;
    logic [DIM_BITS-1:0]       lc2_reg;
    logic [BYTE_ADDR_BITS-1:0] avail2_reg;

    // Stage one: mip extents, copy ends, first layer and free buffer bytes.
    always_comb
    begin
        logic [15:0]             depth1;
        logic [31:0]             layer32;
        logic [31:0]             face32;
        logic [BYTE_ADDR_BITS:0] room;
        depth1  = floor_one(cfg.tex_depth);
        layer32 = 32'(layer_index);
        face32  = {{28{cube_face[3]}}, cube_face};
        mip_bad1_next  = mip_level >= cfg.mip_count;
        face_bad1_next = (cube_face != -4'sd1) && (cfg.tex_kind != KIND_CUBE);
        mw1_next = floor_one(cfg.tex_width >> mip_level);
        mh1_next = floor_one(cfg.tex_height >> mip_level);
        case (cfg.tex_kind)
            KIND_3D:
            begin
                ml1_next   = {3'd0, floor_one(depth1 >> mip_level)};
                loff1_next = layer32;
            end
            KIND_CUBE:
            begin
                ml1_next   = ({3'd0, depth1} << 2) + ({3'd0, depth1} << 1);
                loff1_next = (layer32 << 2) + (layer32 << 1) + face32;
            end
            default:
            begin
                ml1_next   = {3'd0, depth1};
                loff1_next = layer32;
            end
        endcase
        ex1_next = EX_W'(pos_x) + EX_W'(copy_width);
        ey1_next = EX_W'(pos_y) + EX_W'(copy_height);
        bw1_next = (row_length == '0) ? copy_width : row_length;
        bh1_next = (image_rows == '0) ? copy_height : image_rows;
        room = {1'b0, buffer_bytes} - {1'b0, buffer_offset};
        off_gt1_next = room[BYTE_ADDR_BITS];
        avail1_next  = room[BYTE_ADDR_BITS-1:0];
    end

    // Stage two: extent and row checks, ceiling-division numerators.
    always_comb
    begin
        logic [31:0] el;
        el = loff1_reg + 32'(lc1_reg);
        flags2_next.mip_bad    = mip_bad1_reg;
        flags2_next.ext_bad    = (CMP_W'(ex1_reg) > CMP_W'(mw1_reg))
                              || (CMP_W'(ey1_reg) > CMP_W'(mh1_reg))
                              || (el > 32'(ml1_reg));
        flags2_next.row_bad    = (bw1_reg < cw1_reg) || (bh1_reg < ch1_reg);
        flags2_next.ex_at_edge = CMP_W'(ex1_reg) == CMP_W'(mw1_reg);
        flags2_next.ey_at_edge = CMP_W'(ey1_reg) == CMP_W'(mh1_reg);
        flags2_next.face_bad   = face_bad1_reg;
        flags2_next.off_gt     = off_gt1_reg;
        nbw2_next = DW'(bw1_reg) + DW'(bx) - DW'(1);
        nbh2_next = DW'(bh1_reg) + DW'(by) - DW'(1);
        ncw2_next = DW'(cw1_reg) + DW'(bx) - DW'(1);
    end

    // Valid bits of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // Payload of both stages.
    always_ff @(posedge clk)
    begin
        mip_bad1_reg  <= mip_bad1_next;
        face_bad1_reg <= face_bad1_next;
        off_gt1_reg   <= off_gt1_next;
        avail1_reg    <= avail1_next;
        mw1_reg       <= mw1_next;
        mh1_reg       <= mh1_next;
        ml1_reg       <= ml1_next;
        ex1_reg       <= ex1_next;
        ey1_reg       <= ey1_next;
        loff1_reg     <= loff1_next;
        bw1_reg       <= bw1_next;
        bh1_reg       <= bh1_next;
        px1_reg       <= pos_x;
        py1_reg       <= pos_y;
        cw1_reg       <= copy_width;
        ch1_reg       <= copy_height;
        lc1_reg       <= layer_count;

        flags2_reg <= flags2_next;
        px2_reg    <= DW'(px1_reg);
        py2_reg    <= DW'(py1_reg);
        ex2_reg    <= DW'(ex1_reg);
        ey2_reg    <= DW'(ey1_reg);
        nbw2_reg   <= nbw2_next;
        nbh2_reg   <= nbh2_next;
        ncw2_reg   <= ncw2_next;
        lc2_reg    <= lc1_reg;
        avail2_reg <= avail1_reg;
    end

    assign out_valid = v2_reg;
    assign flags     = flags2_reg;
    assign px_div    = px2_reg;
    assign py_div    = py2_reg;
    assign ex_div    = ex2_reg;
    assign ey_div    = ey2_reg;
    assign nbw_div   = nbw2_reg;
    assign nbh_div   = nbh2_reg;
    assign ncw_div   = ncw2_reg;
    assign lc_out    = lc2_reg;
    assign avail_out = avail2_reg;

endmodule

### src/btcc_div.sv
// Pipelined restoring divider lanes by a small divisor, with a side band.
module btcc_div import btcc_pkg::*; #(
    parameter int DW     = DEF_DIM_BITS + 1,
    parameter int LANES  = 7,
    parameter int SIDE_W = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [LANES-1:0][DW-1:0]    dividend,
    input  logic [LANES-1:0][4:0]       divisor,
    input  logic [SIDE_W-1:0]           side_in,
    output logic                        out_valid,
    output logic [LANES-1:0][DW-1:0]    quotient,
    output logic [LANES-1:0][4:0]       remainder,
    output logic [SIDE_W-1:0]           side_out
);

    localparam int NST = (DW + DIV_STEPS - 1) / DIV_STEPS;

    logic [NST-1:0]                       vld_reg;
    logic [NST-1:0][LANES-1:0][DW-1:0]    nq_reg, nq_src, nq_next;
    logic [NST-1:0][LANES-1:0][4:0]       rem_reg, rem_src, rem_next;
    logic [NST-1:0][SIDE_W-1:0]           side_reg;

    // Each stage starts from the previous stage; the first from the inputs.
    // The dividend shifts out at the top while quotient bits shift in below.
    assign nq_src  = {nq_reg[NST-2:0], dividend};
    assign rem_src = {rem_reg[NST-2:0], {LANES{5'd0}}};

    // Up to DIV_STEPS restoring steps per stage and lane.
    always_comb
    begin
        logic [5:0] part;
        part     = '0;
        nq_next  = nq_src;
        rem_next = rem_src;
        for (int s = 0; s < NST; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                for (int k = 0; k < DIV_STEPS; k++)
                begin
                    if (s * DIV_STEPS + k < DW)
                    begin
                        part = {rem_next[s][l], nq_next[s][l][DW-1]};
                        nq_next[s][l] = {nq_next[s][l][DW-2:0], 1'b0};
                        if (part >= {1'b0, divisor[l]})
                        begin
                            part = part - {1'b0, divisor[l]};
                            nq_next[s][l][0] = 1'b1;
                        end
                        rem_next[s][l] = part[4:0];
                    end
                end
            end
        end
    end

    // Valid bits travel with the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        nq_reg   <= nq_next;
        rem_reg  <= rem_next;
        side_reg <= {side_reg[NST-2:0], side_in};
    end

    assign out_valid = vld_reg[NST-1];
    assign quotient  = nq_reg[NST-1];
    assign remainder = rem_reg[NST-1];
    assign side_out  = side_reg[NST-1];

endmodule

### src/btcc_size.sv
// Back stages: buffer copy size, byte range check and result priority.
module btcc_size import btcc_pkg::*; #(
    parameter int DIM_BITS       = DEF_DIM_BITS,
    parameter int BYTE_ADDR_BITS = DEF_BYTE_ADDR_BITS,
    parameter int DW             = DEF_DIM_BITS + 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  btcc_flags_t               flags,
    input  logic [DIM_BITS-1:0]       lc,
    input  logic [BYTE_ADDR_BITS-1:0] avail,
    input  logic [DW-1:0]             bxb,
    input  logic [DW-1:0]             byb,
    input  logic [DW-1:0]             txb,
    input  logic [4:0]                rem_px,
    input  logic [4:0]                rem_py,
    input  logic [4:0]                rem_ex,
    input  logic [4:0]                rem_ey,
    input  logic [5:0]                block_bytes,
    output logic                      done,
    output logic [1:0]                status,
    output logic [2:0]                failed_check
);

    localparam int FW = 2 * DW;
    localparam int PW = (FW < 64) ? FW : 64;

    typedef struct packed {
        logic align_bad;
        logic mip_bad;
        logic ext_bad;
        logic row_bad;
        logic off_gt;
        logic end_bad;
        logic face_bad;
    } verdict_t;

    // Stage registers, one group per back stage.
    logic [3:0]                v_reg;
    verdict_t                  vd1_reg, vd1_next, vd2_reg, vd3_reg, vd4_reg;
    logic [DIM_BITS-1:0]       lc1_reg;
    logic [BYTE_ADDR_BITS-1:0] av1_reg, av2_reg, av3_reg, av4_reg;
    logic [PW-1:0]             p1_reg, p1_next;
    logic [63:0]               diff1_reg, diff1_next, diff2_reg;
    logic [63:0]               lo2_reg, lo2_next;
    logic [31:0]               hi2_reg, hi2_next;
    logic [63:0]               t3_reg, t3_next;
    logic [63:0]               copy4_reg, copy4_next;
    logic                      done_reg;
    logic [1:0]                status_reg, status_next;
    logic [2:0]                check_reg, check_next;

    // Stage one: alignment outcomes, blocks per image and the row slack.
    always_comb
    begin
        logic [FW-1:0] full;
        full = FW'(bxb) * FW'(byb);
        p1_next    = full[PW-1:0];
        diff1_next = 64'(bxb) - 64'(txb);
        vd1_next.align_bad = (rem_px != 5'd0) || (rem_py != 5'd0);
        vd1_next.mip_bad   = flags.mip_bad;
        vd1_next.ext_bad   = flags.ext_bad;
        vd1_next.row_bad   = flags.row_bad;
        vd1_next.off_gt    = flags.off_gt;
        vd1_next.end_bad   = ((rem_ex != 5'd0) && !flags.ex_at_edge)
                          || ((rem_ey != 5'd0) && !flags.ey_at_edge);
        vd1_next.face_bad  = flags.face_bad;
    end

    // Stage two: blocks per image times layers, as two 32-bit halves.
    always_comb
    begin
        logic [63:0] p64;
        logic [31:0] lc32;
        p64      = 64'(p1_reg);
        lc32     = 32'(lc1_reg);
        lo2_next = 64'(p64[31:0]) * 64'(lc32);
        hi2_next = p64[63:32] * lc32;
    end

    // Stage three: merge halves and drop the unused tail of the last row.
    assign t3_next = lo2_reg + {hi2_reg, 32'd0} - diff2_reg;

    // Stage four: scale blocks to bytes.
    assign copy4_next = t3_reg * 64'(block_bytes);

    // Stage five: byte range check and first failed check.
    always_comb
    begin
        logic range_bad;
        range_bad = vd4_reg.off_gt || (copy4_reg > 64'(av4_reg));
        if (vd4_reg.align_bad)
        begin
            status_next = STATUS_INVALID;
            check_next  = CHK_ALIGN;
        end
        else if (vd4_reg.mip_bad)
        begin
            status_next = STATUS_RANGE;
            check_next  = CHK_MIP;
        end
        else if (vd4_reg.ext_bad)
        begin
            status_next = STATUS_RANGE;
            check_next  = CHK_EXTENT;
        end
        else if (vd4_reg.row_bad)
        begin
            status_next = STATUS_INVALID;
            check_next  = CHK_ROW;
        end
        else if (range_bad)
        begin
            status_next = STATUS_RANGE;
            check_next  = CHK_RANGE;
        end
        else if (vd4_reg.end_bad)
        begin
            status_next = STATUS_INVALID;
            check_next  = CHK_END;
        end
        else if (vd4_reg.face_bad)
        begin
            status_next = STATUS_INVALID;
            check_next  = CHK_FACE;
        end
        else
        begin
            status_next = STATUS_OK;
            check_next  = CHK_NONE;
        end
    end

    // Valid bits and the result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v_reg    <= {v_reg[2:0], in_valid};
            done_reg <= v_reg[3];
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        vd1_reg    <= vd1_next;
        lc1_reg    <= lc;
        av1_reg    <= avail;
        p1_reg     <= p1_next;
        diff1_reg  <= diff1_next;

        vd2_reg    <= vd1_reg;
        av2_reg    <= av1_reg;
        lo2_reg    <= lo2_next;
        hi2_reg    <= hi2_next;
        diff2_reg  <= diff1_reg;

        vd3_reg    <= vd2_reg;
        av3_reg    <= av2_reg;
        t3_reg     <= t3_next;

        vd4_reg    <= vd3_reg;
        av4_reg    <= av3_reg;
        copy4_reg  <= copy4_next;

        status_reg <= status_next;
        check_reg  <= check_next;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign failed_check = check_reg;

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the buffer-to-texture copy region checker core.
`timescale 1ns / 100ps

module tb_top;
    import btcc_pkg::*;

    localparam int          STALL_LIMIT = 5000;
    localparam int          DRAIN_CYCLES = 16;
    localparam logic [31:0] CUBE_FACES = 32'd6;
    localparam logic [3:0]  NO_FACE = 4'hF;
    localparam bit          TYPED = 1'b1;
    localparam bit          PREDICTED = 1'b0;
    localparam logic [39:0] ADDR_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [63:0] ADDR_SPAN = 64'h100_0000_0000;

    // One copy descriptor, at the default port widths of the core.
    typedef struct packed {
        logic [15:0]       pos_x;
        logic [15:0]       pos_y;
        logic [4:0]        mip_level;
        logic [15:0]       layer_index;
        logic signed [3:0] cube_face;
        logic [15:0]       copy_width;
        logic [15:0]       copy_height;
        logic [15:0]       layer_count;
        logic [15:0]       row_length;
        logic [15:0]       image_rows;
        logic [39:0]       buffer_offset;
        logic [39:0]       buffer_bytes;
    } copy_desc_t;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] check;
    } verdict_t;

    // Block size and mip extents for one configuration and mip level.
    typedef struct packed {
        logic [31:0] bx;
        logic [31:0] by;
        logic [31:0] mw;
        logic [31:0] mh;
        logic [31:0] ml;
    } geom_t;

    typedef struct {
        int         cfg_sel;
        copy_desc_t d;
        bit         typed;
        verdict_t   v;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [2:0]  failed_check;
    copy_desc_t  desc_drv;
    logic        hint_typed;
    verdict_t    hint_verdict;

    btcc_cfg_t   cur_cfg;
    btcc_cfg_t   dir_cfgs [5];
    stim_row_t   stim_rows [$];
    verdict_t    verdicts_due [$];
    verdict_t    want;
    int          mismatches;
    int          idle_pct;
    int          stall_cycles;
    int          cur_sel;

    buffer_texture_copy_region_check_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .start         (start),
        .busy          (busy),
        .pos_x         (desc_drv.pos_x),
        .pos_y         (desc_drv.pos_y),
        .mip_level     (desc_drv.mip_level),
        .layer_index   (desc_drv.layer_index),
        .cube_face     (desc_drv.cube_face),
        .copy_width    (desc_drv.copy_width),
        .copy_height   (desc_drv.copy_height),
        .layer_count   (desc_drv.layer_count),
        .row_length    (desc_drv.row_length),
        .image_rows    (desc_drv.image_rows),
        .buffer_offset (desc_drv.buffer_offset),
        .buffer_bytes  (desc_drv.buffer_bytes),
        .done          (done),
        .status        (status),
        .failed_check  (failed_check)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Block size with zero taken as one, and the floored mip extents.
    function automatic geom_t geometry(input btcc_cfg_t c, input logic [4:0] mip);
        geom_t g;
        g.bx = (c.block_width == '0) ? 32'd1 : 32'(c.block_width);
        g.by = (c.block_height == '0) ? 32'd1 : 32'(c.block_height);
        g.mw = 32'(c.tex_width) >> mip;
        g.mh = 32'(c.tex_height) >> mip;
        g.ml = (c.tex_depth == '0) ? 32'd1 : 32'(c.tex_depth);
        if (g.mw == '0)
            g.mw = 32'd1;
        if (g.mh == '0)
            g.mh = 32'd1;
        if (c.tex_kind == KIND_3D)
        begin
            g.ml = g.ml >> mip;
            if (g.ml == '0)
                g.ml = 32'd1;
        end
        else if (c.tex_kind == KIND_CUBE)
            g.ml = g.ml * CUBE_FACES;
        return g;
    endfunction

    // Bytes the copy spans in the buffer; wraps at 64 bits on a zero layer count.
    function automatic logic [63:0] copy_bytes(input copy_desc_t d, input btcc_cfg_t c);
        geom_t       g;
        logic [63:0] rw;
        logic [63:0] rh;
        logic [63:0] bxb;
        logic [63:0] byb;
        logic [63:0] txb;
        g = geometry(c, d.mip_level);
        rw = (d.row_length == '0) ? 64'(d.copy_width) : 64'(d.row_length);
        rh = (d.image_rows == '0) ? 64'(d.copy_height) : 64'(d.image_rows);
        bxb = (rw + 64'(g.bx) - 64'd1) / 64'(g.bx);
        byb = (rh + 64'(g.by) - 64'd1) / 64'(g.by);
        txb = (64'(d.copy_width) + 64'(g.bx) - 64'd1) / 64'(g.bx);
        return (bxb * byb * 64'(d.layer_count) - (bxb - txb)) * 64'(c.block_bytes);
    endfunction

    // Runs the seven checks in priority order and returns the first failure.
    function automatic verdict_t check_region(input copy_desc_t d, input btcc_cfg_t c);
        geom_t       g;
        logic [31:0] face;
        logic [31:0] loff;
        logic [31:0] ex;
        logic [31:0] ey;
        logic [31:0] el;
        logic [31:0] bw;
        logic [31:0] bh;
        logic [63:0] off;
        logic [63:0] size;
        g = geometry(c, d.mip_level);
        face = {{28{d.cube_face[3]}}, d.cube_face};
        loff = 32'(d.layer_index);
        if (c.tex_kind == KIND_CUBE)
            loff = loff * CUBE_FACES + face;
        ex = 32'(d.pos_x) + 32'(d.copy_width);
        ey = 32'(d.pos_y) + 32'(d.copy_height);
        el = loff + 32'(d.layer_count);
        bw = (d.row_length == '0) ? 32'(d.copy_width) : 32'(d.row_length);
        bh = (d.image_rows == '0) ? 32'(d.copy_height) : 32'(d.image_rows);
        off = 64'(d.buffer_offset);
        size = 64'(d.buffer_bytes);
        if ((32'(d.pos_x) % g.bx) != '0 || (32'(d.pos_y) % g.by) != '0)
            return {STATUS_INVALID, CHK_ALIGN};
        if (d.mip_level >= c.mip_count)
            return {STATUS_RANGE, CHK_MIP};
        if (ex > g.mw || ey > g.mh || el > g.ml)
            return {STATUS_RANGE, CHK_EXTENT};
        if (bw < 32'(d.copy_width) || bh < 32'(d.copy_height))
            return {STATUS_INVALID, CHK_ROW};
        if (off > size || copy_bytes(d, c) > size - off)
            return {STATUS_RANGE, CHK_RANGE};
        if (((ex % g.bx) != '0 && ex != g.mw) || ((ey % g.by) != '0 && ey != g.mh))
            return {STATUS_INVALID, CHK_END};
        if (c.tex_kind != KIND_CUBE && d.cube_face != NO_FACE)
            return {STATUS_INVALID, CHK_FACE};
        return {STATUS_OK, CHK_NONE};
    endfunction

    function automatic btcc_cfg_t mk_cfg(input logic [4:0] bw, input logic [4:0] bh,
                                         input logic [5:0] bb, input logic [4:0] mips,
                                         input logic [15:0] w, input logic [15:0] h,
                                         input logic [15:0] dpt, input logic [1:0] kind);
        btcc_cfg_t c;
        c.block_width = bw;
        c.block_height = bh;
        c.block_bytes = bb;
        c.mip_count = mips;
        c.tex_width = w;
        c.tex_height = h;
        c.tex_depth = dpt;
        c.tex_kind = kind;
        return c;
    endfunction

    // Random texture description, mostly small so that valid copies fit the buffer.
    function automatic btcc_cfg_t rand_cfg();
        btcc_cfg_t c;
        c.block_width = ($urandom_range(3) == 0) ? 5'($urandom) : 5'(1 << $urandom_range(2));
        c.block_height = ($urandom_range(3) == 0) ? 5'($urandom) : 5'(1 << $urandom_range(2));
        c.block_bytes = 6'($urandom);
        c.mip_count = ($urandom_range(7) == 0) ? 5'($urandom) : 5'($urandom_range(16, 1));
        c.tex_width = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(300, 1));
        c.tex_height = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(300, 1));
        c.tex_depth = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(16));
        c.tex_kind = 2'($urandom);
        return c;
    endfunction

    // Random descriptor: some pure noise, the rest well formed for the current
    // texture with a few fields broken now and then.
    function automatic copy_desc_t rand_desc(input btcc_cfg_t c);
        copy_desc_t  d;
        geom_t       g;
        logic [31:0] ex;
        logic [31:0] ey;
        logic [31:0] loff;
        logic [31:0] room;
        logic [63:0] need;
        logic [63:0] total;
        d.pos_x = 16'($urandom);
        d.pos_y = 16'($urandom);
        d.mip_level = 5'($urandom);
        d.layer_index = 16'($urandom);
        d.cube_face = 4'($urandom);
        d.copy_width = 16'($urandom);
        d.copy_height = 16'($urandom);
        d.layer_count = 16'($urandom);
        d.row_length = 16'($urandom);
        d.image_rows = 16'($urandom);
        d.buffer_offset = 40'({$urandom, $urandom});
        d.buffer_bytes = 40'({$urandom, $urandom});
        if ($urandom_range(99) < 20)
            return d;

        if (c.mip_count != '0)
            d.mip_level = 5'($urandom_range(32'(c.mip_count) - 32'd1));
        g = geometry(c, d.mip_level);

        // Aligned start, end on a block boundary or at the mip edge.
        d.pos_x = 16'(g.bx * $urandom_range(g.mw / g.bx));
        d.pos_y = 16'(g.by * $urandom_range(g.mh / g.by));
        ex = ($urandom_range(3) == 0) ? g.mw
             : g.bx * $urandom_range(g.mw / g.bx, 32'(d.pos_x) / g.bx);
        ey = ($urandom_range(3) == 0) ? g.mh
             : g.by * $urandom_range(g.mh / g.by, 32'(d.pos_y) / g.by);
        d.copy_width = 16'(ex - 32'(d.pos_x));
        d.copy_height = 16'(ey - 32'(d.pos_y));

        // Layers inside the texture, with a face only on a cube.
        if (c.tex_kind == KIND_CUBE)
        begin
            d.cube_face = 4'($urandom_range(5));
            d.layer_index = 16'($urandom_range(g.ml / CUBE_FACES - 32'd1));
            loff = 32'(d.layer_index) * CUBE_FACES + 32'(d.cube_face);
        end
        else
        begin
            d.cube_face = NO_FACE;
            d.layer_index = 16'($urandom_range(g.ml - 32'd1));
            loff = 32'(d.layer_index);
        end
        room = g.ml - loff;
        if (room > 32'd65535)
            room = 32'd65535;
        if ($urandom_range(3) != 0 && room > 32'd8)
            room = 32'd8;
        d.layer_count = 16'($urandom_range(room));

        d.row_length = ($urandom_range(1) == 0) ? '0
                       : 16'(32'(d.copy_width) + $urandom_range(16));
        d.image_rows = ($urandom_range(1) == 0) ? '0
                       : 16'(32'(d.copy_height) + $urandom_range(16));
        if ($urandom_range(9) == 0)
            d.row_length = 16'($urandom_range(32'(d.copy_width)));
        if ($urandom_range(9) == 0)
            d.cube_face = 4'($urandom);

        // Buffer sized at, just under, or a little over what the copy needs.
        d.buffer_offset = ($urandom_range(3) == 0) ? 40'({$urandom, $urandom})
                          : 40'($urandom_range(4095));
        need = copy_bytes(d, c);
        total = 64'(d.buffer_offset) + need;
        if (need < ADDR_SPAN && total < ADDR_SPAN)
        begin
            case ($urandom_range(3))
                0: d.buffer_bytes = 40'(total);
                1: d.buffer_bytes = 40'(total - 64'd1);
                default: d.buffer_bytes = 40'(total + 64'($urandom_range(4096)));
            endcase
        end
        return d;
    endfunction

    task automatic add_row(input int sel, input bit typed, input logic [1:0] st,
                           input logic [2:0] ck, input logic [15:0] px,
                           input logic [15:0] py, input logic [4:0] mip,
                           input logic [15:0] layer, input logic [3:0] face,
                           input logic [15:0] cw, input logic [15:0] ch,
                           input logic [15:0] lc, input logic [15:0] rl,
                           input logic [15:0] ir, input logic [39:0] off,
                           input logic [39:0] bytes);
        stim_row_t r;
        r.cfg_sel = sel;
        r.typed = typed;
        r.v = {st, ck};
        r.d = {px, py, mip, layer, face, cw, ch, lc, rl, ir, off, bytes};
        stim_rows.push_back(r);
    endtask

    task automatic flag_error(input string what);
        if (mismatches < 10)
            $display("ERROR: %s", what);
        mismatches++;
    endtask

    // One APB write: setup cycle, then access until pready.
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val, input int w);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= (($urandom >> w) << w) | val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
    endtask

    // Loads the whole texture description; called only while nothing is in flight.
    task automatic write_cfg(input btcc_cfg_t c);
        apb_write(REG_BLOCK_WIDTH, 32'(c.block_width), 5);
        apb_write(REG_BLOCK_HEIGHT, 32'(c.block_height), 5);
        apb_write(REG_BLOCK_BYTES, 32'(c.block_bytes), 6);
        apb_write(REG_MIP_COUNT, 32'(c.mip_count), 5);
        apb_write(REG_TEX_WIDTH, 32'(c.tex_width), 16);
        apb_write(REG_TEX_HEIGHT, 32'(c.tex_height), 16);
        apb_write(REG_TEX_DEPTH, 32'(c.tex_depth), 16);
        apb_write(REG_TEX_KIND, 32'(c.tex_kind), 2);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_cfg = c;
    endtask

    // Offers one descriptor after a random gap and returns at its transfer edge.
    task automatic send_desc(input copy_desc_t d, input bit typed, input verdict_t v);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        desc_drv <= d;
        hint_typed <= typed;
        hint_verdict <= v;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Stops offering descriptors until every pending verdict has come back.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (verdicts_due.size() != 0)
            @(posedge clk);
    endtask

    // Scoreboard: check the result strobe, then record the descriptor transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (verdicts_due.size() == 0)
                    flag_error($sformatf("result with nothing pending: status %0d check %0d",
                                         status, failed_check));
                else
                begin
                    want = verdicts_due.pop_front();
                    if (status !== want.status || failed_check !== want.check)
                        flag_error($sformatf("status exp %0d got %0d, check exp %0d got %0d",
                                             want.status, status, want.check, failed_check));
                end
            end
            if (start && !busy)
                verdicts_due.push_back(hint_typed ? hint_verdict
                                                  : check_region(desc_drv, cur_cfg));
        end
    end

    // Watchdog on cycles without any transfer or result.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (psel && penable && pready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Stimulus sequence.
    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        start <= 1'b0;
        desc_drv <= '0;
        hint_typed <= 1'b0;
        hint_verdict <= '0;
        mismatches = 0;
        stall_cycles = 0;
        idle_pct = 37;
        cur_cfg = CFG_RESET;
        cur_sel = 0;

        dir_cfgs[0] = CFG_RESET;
        dir_cfgs[1] = mk_cfg(4, 4, 16, 5, 64, 64, 2, KIND_CUBE);
        dir_cfgs[2] = mk_cfg(3, 2, 8, 7, 100, 50, 40, KIND_3D);
        dir_cfgs[3] = mk_cfg(0, 0, 0, 0, 0, 0, 0, 2'd0);
        dir_cfgs[4] = mk_cfg(31, 31, 63, 31, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd1);

        // Reset texture: 1x1x1, 2D, one mip, 4-byte texels.
        add_row(0, TYPED, STATUS_OK, CHK_NONE,
                0, 0, 0, 0, NO_FACE, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, TYPED, STATUS_RANGE, CHK_MIP,
                0, 0, 1, 0, NO_FACE, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, TYPED, STATUS_RANGE, CHK_EXTENT,
                0, 0, 0, 0, NO_FACE, 2, 0, 0, 0, 0, 0, 0);
        add_row(0, TYPED, STATUS_RANGE, CHK_EXTENT,
                0, 0, 0, 0, NO_FACE, 0, 0, 2, 0, 0, 0, 0);
        add_row(0, TYPED, STATUS_RANGE, CHK_RANGE,
                0, 0, 0, 0, NO_FACE, 1, 1, 1, 0, 0, 0, 3);
        add_row(0, TYPED, STATUS_OK, CHK_NONE,
                0, 0, 0, 0, NO_FACE, 1, 1, 1, 0, 0, 0, 4);
        add_row(0, TYPED, STATUS_INVALID, CHK_FACE,
                0, 0, 0, 0, 4'h0, 1, 1, 1, 0, 0, 0, 4);
        add_row(0, TYPED, STATUS_RANGE, CHK_MIP,
                16'hFFFF, 16'hFFFF, 31, 16'hFFFF, 4'h7, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                16'hFFFF, 16'hFFFF, ADDR_MAX, ADDR_MAX);
        add_row(0, TYPED, STATUS_RANGE, CHK_RANGE,
                0, 0, 0, 0, NO_FACE, 1, 1, 1, 0, 0, 5, 4);
        // Zero layers with a wide buffer row: the size term wraps around.
        add_row(0, TYPED, STATUS_RANGE, CHK_RANGE,
                0, 0, 0, 0, NO_FACE, 1, 1, 0, 5, 0, 0, ADDR_MAX);

        // Cube with 4x4 blocks; a face of -1 or any 4-bit face feeds the layer math.
        add_row(1, TYPED, STATUS_INVALID, CHK_ALIGN,
                2, 0, 0, 0, NO_FACE, 0, 0, 0, 0, 0, 0, 0);
        add_row(1, PREDICTED, STATUS_OK, CHK_NONE,
                0, 0, 0, 0, 4'h0, 16, 16, 6, 0, 0, 0, 1536);
        add_row(1, PREDICTED, STATUS_OK, CHK_NONE,
                0, 0, 0, 0, NO_FACE, 4, 4, 1, 0, 0, 0, 4096);
        add_row(1, PREDICTED, STATUS_OK, CHK_NONE,
                0, 0, 0, 1, NO_FACE, 4, 4, 1, 0, 0, 0, 4096);
        add_row(1, PREDICTED, STATUS_OK, CHK_NONE,
                0, 0, 0, 1, 4'h7, 4, 4, 1, 0, 0, 0, 4096);
        add_row(1, PREDICTED, STATUS_OK, CHK_NONE,
                0, 0, 0, 2, 4'h8, 4, 4, 1, 0, 0, 0, 4096);
        add_row(1, TYPED, STATUS_INVALID, CHK_ROW,
                0, 0, 0, 0, 4'h0, 16, 4, 1, 8, 0, 0, 4096);
        add_row(1, TYPED, STATUS_INVALID, CHK_ROW,
                0, 0, 0, 0, 4'h0, 16, 16, 1, 0, 4, 0, 4096);
        add_row(1, PREDICTED, STATUS_OK, CHK_NONE,
                0, 0, 0, 0, 4'h0, 6, 4, 1, 0, 0, 0, 4096);
        add_row(1, PREDICTED, STATUS_OK, CHK_NONE,
                0, 0, 4, 0, 4'h0, 4, 4, 1, 0, 0, 0, 4096);
        add_row(1, TYPED, STATUS_RANGE, CHK_MIP,
                0, 0, 5, 0, 4'h0, 4, 4, 1, 0, 0, 0, 4096);

        // 3D texture: unaligned copy end that reaches the mip edge, shrunk depth.
        add_row(2, PREDICTED, STATUS_OK, CHK_NONE,
                24, 0, 2, 0, NO_FACE, 1, 12, 10, 0, 0, 0, ADDR_MAX);
        add_row(2, PREDICTED, STATUS_OK, CHK_NONE,
                0, 0, 6, 0, NO_FACE, 1, 1, 2, 0, 0, 0, ADDR_MAX);
        add_row(2, PREDICTED, STATUS_OK, CHK_NONE,
                0, 0, 0, 0, 4'h3, 3, 2, 1, 0, 0, 0, ADDR_MAX);

        // Zero block sizes count as one; a zero mip count fails every descriptor.
        add_row(3, TYPED, STATUS_RANGE, CHK_MIP,
                7, 0, 0, 0, NO_FACE, 1, 1, 1, 0, 0, 0, 0);

        // Largest texture and block sizes.
        add_row(4, TYPED, STATUS_INVALID, CHK_ALIGN,
                16'hFFFF, 0, 0, 0, NO_FACE, 0, 0, 0, 0, 0, 0, 0);
        add_row(4, PREDICTED, STATUS_OK, CHK_NONE,
                65503, 0, 0, 0, NO_FACE, 32, 31, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, ADDR_MAX);
        add_row(4, PREDICTED, STATUS_OK, CHK_NONE,
                0, 0, 30, 0, NO_FACE, 1, 1, 1, 0, 0, 0, ADDR_MAX);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, reloading the texture whenever a row asks for another one.
        foreach (stim_rows[i])
        begin
            if (stim_rows[i].cfg_sel != cur_sel)
            begin
                wait_drained();
                write_cfg(dir_cfgs[stim_rows[i].cfg_sel]);
                cur_sel = stim_rows[i].cfg_sel;
            end
            send_desc(stim_rows[i].d, stim_rows[i].typed, stim_rows[i].v);
        end

        // Random phases, each with its own texture and sender gap rate.
        for (int p = 0; p < 8; p++)
        begin
            wait_drained();
            if (p == 2)
                write_cfg(dir_cfgs[4]);
            else if (p == 6)
                write_cfg(dir_cfgs[1]);
            else
                write_cfg(rand_cfg());
            idle_pct = (p < 3) ? 37 : (p < 6) ? 69 : 0;
            for (int n = 0; n < 50; n++)
            begin
                // Halfway through, hold off until the pipeline is empty.
                if (n == 25)
                    wait_drained();
                send_desc(rand_desc(cur_cfg), PREDICTED, '0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (verdicts_due.size() != 0)
            flag_error($sformatf("%0d results never arrived", verdicts_due.size()));
        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

### files.f
src/btcc_pkg.sv
src/btcc_front.sv
src/btcc_div.sv
src/btcc_size.sv
src/buffer_texture_copy_region_check_core.sv
tb/sv/tb_top.sv
